// ===== hdl/ssvm_pkg.sv =====
// shared types and constants of the sparse set value map
package ssvm_pkg;

    localparam int unsigned KEYS    = 1024;
    localparam int unsigned KEY_W   = 11;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned TDATA_W = 48;

    localparam logic [VAL_W-1:0] VALUE_NONE = '1;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic slot;
        logic eval;
        logic move;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic need_move;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/sparse_set_value_map.sv =====
// top level of the sparse set value map
// an item is accepted in idle and steps through slot, eval and done, with a move state
// after eval for a remove of a member that leaves others in the set; done waits while
// the previous result is held, and no new item is accepted before idle. the steps are
// set by the dependent registered reads of the sparse and dense stores. synchronous
// active-low reset empties the set by zeroing the count; the stores are not cleared
module sparse_set_value_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ssvm_pkg::TDATA_W-1:0]  s_axis_tdata,  // key, value
    input  logic [1:0]                    s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ssvm_pkg::TDATA_W-1:0]  m_axis_tdata,  // read_value, member_count
    output logic                          m_axis_tuser   // was_member
);

    localparam int unsigned KEY_W = ssvm_pkg::KEY_W;
    localparam int unsigned VAL_W = ssvm_pkg::VAL_W;
    localparam int unsigned CNT_W = ssvm_pkg::CNT_W;

    ssvm_pkg::t_cmd    cmd;
    ssvm_pkg::t_status status;
    logic [VAL_W-1:0]  read_value;
    logic [CNT_W-1:0]  member_count;

    ssvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ssvm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_op           (ssvm_pkg::t_op'(s_axis_tuser)),
        .i_key          (s_axis_tdata[KEY_W-1:0]),
        .i_value        (s_axis_tdata[KEY_W+VAL_W-1:KEY_W]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_was_member   (m_axis_tuser),
        .o_read_value   (read_value),
        .o_member_count (member_count)
    );

    assign m_axis_tdata = {{(ssvm_pkg::TDATA_W - VAL_W - CNT_W){1'b0}}, member_count, read_value};

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while another is in flight");

    a_absent_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[VAL_W-1:0] == ssvm_pkg::VALUE_NONE))
        else $error("absent key reported a stored value");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[VAL_W+CNT_W-1:VAL_W] <= CNT_W'(ssvm_pkg::KEYS)))
        else $error("member count above capacity");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.slot, cmd.eval, cmd.move, cmd.publish}))
        else $error("more than one datapath command at once");

endmodule

// ===== hdl/ssvm_ram.sv =====
// generic single write port ram with registered read
module ssvm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ssvm_ctrl.sv =====
// controller state machine of the sparse set value map
module ssvm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ssvm_pkg::t_status i_status,
    output ssvm_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SLOT = 5'b00010,
        S_EVAL = 5'b00100,
        S_MOVE = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SLOT;
                end
            end
            S_SLOT: begin
                o_cmd.slot = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_move ? S_MOVE : S_DONE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/ssvm_dp.sv =====
// datapath of the sparse set value map: stores, count and result register
module ssvm_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ssvm_pkg::t_cmd                    i_cmd,
    output ssvm_pkg::t_status                 o_status,
    input  ssvm_pkg::t_op                     i_op,
    input  logic [ssvm_pkg::KEY_W-1:0]        i_key,
    input  logic [ssvm_pkg::VAL_W-1:0]        i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_was_member,
    output logic [ssvm_pkg::VAL_W-1:0]        o_read_value,
    output logic [ssvm_pkg::CNT_W-1:0]        o_member_count
);

    localparam int unsigned KEY_W = ssvm_pkg::KEY_W;
    localparam int unsigned IDX_W = ssvm_pkg::IDX_W;
    localparam int unsigned VAL_W = ssvm_pkg::VAL_W;
    localparam int unsigned CNT_W = ssvm_pkg::CNT_W;
    localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(ssvm_pkg::KEYS);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ssvm_pkg::KEYS);

    ssvm_pkg::t_op    r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [IDX_W-1:0] r_slot;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_member;
    logic [VAL_W-1:0] r_rd;
    logic             r_out_valid;
    logic             r_out_member;
    logic [VAL_W-1:0] r_out_value;
    logic [CNT_W-1:0] r_out_count;

    logic [KEY_W-1:0] in_key_m1;
    logic [KEY_W-1:0] key_m1;
    logic [KEY_W-1:0] last_m1;
    logic [CNT_W-1:0] cnt_m1;
    logic             key_ok;
    logic             last_ok;
    logic             member;

    logic [VAL_W-1:0] value_q;
    logic [IDX_W-1:0] sparse_q;
    logic [KEY_W-1:0] dense_q;

    logic             val_we;
    logic [VAL_W-1:0] val_wdata;
    logic             sp_we;
    logic [IDX_W-1:0] sp_waddr;
    logic [IDX_W-1:0] sp_wdata;
    logic             dn_we;
    logic [IDX_W-1:0] dn_waddr;
    logic [KEY_W-1:0] dn_wdata;
    logic             dn_re;
    logic [IDX_W-1:0] dn_raddr;
    logic             need_move;

    assign in_key_m1 = i_key - KEY_W'(1);
    assign key_m1    = r_key - KEY_W'(1);
    assign last_m1   = dense_q - KEY_W'(1);
    assign cnt_m1    = r_count - CNT_W'(1);
    assign key_ok    = (r_key != '0) && (r_key <= KEY_MAX);
    assign last_ok   = (dense_q != '0) && (dense_q <= KEY_MAX);
    assign member    = key_ok && ({1'b0, r_slot} < r_count) && (dense_q == r_key);

    always_comb begin
        n_count   = r_count;
        val_we    = 1'b0;
        val_wdata = r_value;
        sp_we     = 1'b0;
        sp_waddr  = key_m1[IDX_W-1:0];
        sp_wdata  = r_count[IDX_W-1:0];
        dn_we     = 1'b0;
        dn_waddr  = r_count[IDX_W-1:0];
        dn_wdata  = r_key;
        dn_re     = i_cmd.slot;
        dn_raddr  = i_cmd.slot ? sparse_q : cnt_m1[IDX_W-1:0];
        need_move = 1'b0;
        if (i_cmd.eval) begin
            case (r_op)
                ssvm_pkg::OP_INSERT: begin
                    if (key_ok) begin
                        if (member) begin
                            val_we = 1'b1;
                        end else if (r_count < CNT_MAX) begin
                            val_we  = 1'b1;
                            sp_we   = 1'b1;
                            dn_we   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
                ssvm_pkg::OP_REMOVE: begin
                    if (key_ok) begin
                        val_we    = 1'b1;
                        val_wdata = ssvm_pkg::VALUE_NONE;
                        if (member) begin
                            n_count   = cnt_m1;
                            dn_re     = 1'b1;
                            need_move = (cnt_m1 != '0);
                        end
                    end
                end
                ssvm_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                ssvm_pkg::OP_QUERY: begin
                    n_count = r_count;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
        if (i_cmd.move && last_ok) begin
            sp_we    = 1'b1;
            sp_waddr = last_m1[IDX_W-1:0];
            sp_wdata = r_slot;
            dn_we    = 1'b1;
            dn_waddr = r_slot;
            dn_wdata = dense_q;
        end
    end

    ssvm_ram #(.WIDTH(VAL_W), .DEPTH(ssvm_pkg::KEYS)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (key_m1[IDX_W-1:0]),
        .i_wdata (val_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (in_key_m1[IDX_W-1:0]),
        .o_rdata (value_q)
    );

    ssvm_ram #(.WIDTH(IDX_W), .DEPTH(ssvm_pkg::KEYS)) u_sparse_ram (
        .i_clk   (i_clk),
        .i_we    (sp_we),
        .i_waddr (sp_waddr),
        .i_wdata (sp_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (in_key_m1[IDX_W-1:0]),
        .o_rdata (sparse_q)
    );

    ssvm_ram #(.WIDTH(KEY_W), .DEPTH(ssvm_pkg::KEYS)) u_dense_ram (
        .i_clk   (i_clk),
        .i_we    (dn_we),
        .i_waddr (dn_waddr),
        .i_wdata (dn_wdata),
        .i_re    (dn_re),
        .i_raddr (dn_raddr),
        .o_rdata (dense_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.slot) begin
            r_slot <= sparse_q;
        end
        if (i_cmd.eval) begin
            r_member <= member;
            r_rd     <= member ? value_q : ssvm_pkg::VALUE_NONE;
        end
        if (i_cmd.publish) begin
            r_out_member <= r_member;
            r_out_value  <= r_rd;
            r_out_count  <= r_count;
        end
    end

    assign o_status.need_move = need_move;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_was_member       = r_out_member;
    assign o_read_value       = r_out_value;
    assign o_member_count     = r_out_count;

endmodule
